>>> src/rpa_pkg.sv
package rpa_pkg;

  // Field widths fixed by the interface
  localparam int ADDR_W     = 36;
  localparam int REF_W      = 8;
  localparam int STATUS_W   = 2;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 4;

  // Default configuration of the allocator
  localparam int NUM_PAGES_DEF  = 32768;
  localparam int PAGE_SHIFT_DEF = 12;
  localparam int COUNT_BITS_DEF = 8;

  // Queue depths between the parts
  localparam int MID_DEPTH = 2;
  localparam int OUT_DEPTH = 2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOFREE   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BADADDR  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_STILLREF = 2'd3;

  // Register indexes (selected by paddr bit 3)
  localparam logic REG_FLOOR = 1'b0;
  localparam logic REG_TOP   = 1'b1;

  // Register reset values
  localparam logic [ADDR_W-1:0] FLOOR_RESET = 36'h0_8000_0000;
  localparam logic [ADDR_W-1:0] TOP_RESET   = 36'h0_8800_0000;

  typedef struct packed {
    logic              mode;
    logic [ADDR_W-1:0] page_addr;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic [ADDR_W-1:0]       result_addr;
    logic signed [REF_W-1:0] ref_count;
  } out_t;

endpackage

>>> src/rpa_fifo.sv
module rpa_fifo #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             push_ok, pop_ok;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign rdata   = mem[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_ok) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop_ok) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push_ok && !pop_ok) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop_ok && !push_ok) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the beat
  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

endmodule

>>> src/rpa_cfg.sv
module rpa_cfg (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_psel,
  input  logic                                  cfg_penable,
  input  logic                                  cfg_pwrite,
  input  logic [rpa_pkg::CFG_ADDR_W-1:0]        cfg_paddr,
  input  logic [rpa_pkg::CFG_DATA_W-1:0]        cfg_pwdata,
  output logic [rpa_pkg::CFG_DATA_W-1:0]        cfg_prdata,
  output logic                                  cfg_pready,
  output logic [rpa_pkg::ADDR_W-1:0]            mem_floor,
  output logic [rpa_pkg::ADDR_W-1:0]            mem_top
);

  logic [rpa_pkg::ADDR_W-1:0] floor_r, floor_nxt;
  logic [rpa_pkg::ADDR_W-1:0] top_r, top_nxt;
  logic                       wr_en;
  logic                       reg_sel;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_sel    = cfg_paddr[rpa_pkg::CFG_ADDR_W-1];
  assign mem_floor  = floor_r;
  assign mem_top    = top_r;

  // Decode the write
  always_comb begin
    floor_nxt = floor_r;
    top_nxt   = top_r;
    if (wr_en) begin
      case (reg_sel)
        rpa_pkg::REG_FLOOR: floor_nxt = cfg_pwdata[rpa_pkg::ADDR_W-1:0];
        rpa_pkg::REG_TOP:   top_nxt   = cfg_pwdata[rpa_pkg::ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the selected register
  always_comb begin
    case (reg_sel)
      rpa_pkg::REG_FLOOR: cfg_prdata = rpa_pkg::CFG_DATA_W'(floor_r);
      rpa_pkg::REG_TOP:   cfg_prdata = rpa_pkg::CFG_DATA_W'(top_r);
      default:            cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      floor_r <= rpa_pkg::FLOOR_RESET;
      top_r   <= rpa_pkg::TOP_RESET;
    end else begin
      floor_r <= floor_nxt;
      top_r   <= top_nxt;
    end
  end

endmodule

>>> src/rpa_front.sv
module rpa_front #(
  parameter int NUM_PAGES  = rpa_pkg::NUM_PAGES_DEF,
  parameter int PAGE_SHIFT = rpa_pkg::PAGE_SHIFT_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          in_push,
  input  rpa_pkg::in_t                                  in_data,
  output logic                                          in_full,
  input  logic [rpa_pkg::ADDR_W-1:0]                    mem_floor,
  input  logic [rpa_pkg::ADDR_W-1:0]                    mem_top,
  input  logic                                          clr_busy,
  input  logic                                          mid_full,
  output logic                                          mid_push,
  output logic                                          mid_mode,
  output logic                                          mid_bad,
  output logic [rpa_pkg::ADDR_W-PAGE_SHIFT-1:0]         mid_pnum,
  output logic [$clog2(NUM_PAGES)-1:0]                  mid_slot
);

  localparam int  PN_W    = rpa_pkg::ADDR_W - PAGE_SHIFT;
  localparam int  SLOT_W  = $clog2(NUM_PAGES);
  localparam int  EXT_W   = (PN_W > SLOT_W) ? PN_W : SLOT_W;
  localparam int  STEP_W  = 2;
  localparam bit  IS_POW2 = ((NUM_PAGES & (NUM_PAGES - 1)) == 0);

  // Reciprocal of NUM_PAGES scaled by 2^(PN_W + SLOT_W); its quotient is low by at most one
  localparam int  RCP_SH  = PN_W + SLOT_W;
  localparam int  RCP_W   = PN_W + 1;
  localparam int  PROD_W  = PN_W + RCP_W;
  localparam longint unsigned RCP_FULL = (64'd1 << RCP_SH) / NUM_PAGES;
  localparam logic [RCP_W-1:0] RCP = RCP_W'(RCP_FULL);

  logic               hold_r, hold_nxt;
  logic [STEP_W-1:0]  steps_r, steps_nxt;
  logic               mode_r, mode_nxt;
  logic               bad_r, bad_nxt;
  logic [PN_W-1:0]    pnum_r, pnum_nxt;
  logic [PN_W-1:0]    quo_r, quo_nxt;
  logic [SLOT_W-1:0]  rem_r, rem_nxt;

  logic               accept;
  logic [PN_W-1:0]    in_pnum;
  logic [EXT_W-1:0]   in_pnum_ext;
  logic               in_bad;
  logic [PROD_W-1:0]  prod;
  logic [EXT_W:0]     quo_mul;
  logic [EXT_W:0]     rem_est;
  logic [EXT_W:0]     rem_fix;

  assign mid_push = hold_r && (steps_r == '0) && !mid_full;
  assign in_full  = clr_busy || (hold_r && !mid_push);
  assign accept   = in_push && !in_full;

  assign mid_mode = mode_r;
  assign mid_bad  = bad_r;
  assign mid_pnum = pnum_r;
  assign mid_slot = rem_r;

  // Classify the incoming request: alignment and window check on a free
  assign in_pnum     = in_data.page_addr[rpa_pkg::ADDR_W-1:PAGE_SHIFT];
  assign in_pnum_ext = EXT_W'(in_pnum);
  assign in_bad      = in_data.mode &&
                       ((in_data.page_addr[PAGE_SHIFT-1:0] != '0) ||
                        (in_data.page_addr < mem_floor) ||
                        (in_data.page_addr >= mem_top));

  // Slot of a page number: estimate the quotient, then one correcting subtract
  assign prod    = PROD_W'(pnum_r) * PROD_W'(RCP);
  assign quo_mul = (EXT_W + 1)'(quo_r) * (EXT_W + 1)'(NUM_PAGES);
  assign rem_est = (EXT_W + 1)'(pnum_r) - quo_mul;
  assign rem_fix = (rem_est >= (EXT_W + 1)'(NUM_PAGES)) ?
                   rem_est - (EXT_W + 1)'(NUM_PAGES) : rem_est;

  always_comb begin
    hold_nxt  = hold_r;
    steps_nxt = steps_r;
    mode_nxt  = mode_r;
    bad_nxt   = bad_r;
    pnum_nxt  = pnum_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    if (accept) begin
      hold_nxt = 1'b1;
      mode_nxt = in_data.mode;
      bad_nxt  = in_bad;
      pnum_nxt = in_pnum;
      if (IS_POW2) begin
        rem_nxt   = in_pnum_ext[SLOT_W-1:0];
        steps_nxt = '0;
      end else begin
        rem_nxt   = '0;
        steps_nxt = (in_data.mode && !in_bad) ? STEP_W'(2) : '0;
      end
    end else if (mid_push) begin
      hold_nxt = 1'b0;
    end else if (hold_r && (steps_r == STEP_W'(2))) begin
      quo_nxt   = PN_W'(prod >> RCP_SH);
      steps_nxt = STEP_W'(1);
    end else if (hold_r && (steps_r == STEP_W'(1))) begin
      rem_nxt   = rem_fix[SLOT_W-1:0];
      steps_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r  <= 1'b0;
      steps_r <= '0;
    end else begin
      hold_r  <= hold_nxt;
      steps_r <= steps_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r <= mode_nxt;
    bad_r  <= bad_nxt;
    pnum_r <= pnum_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
  end

endmodule

>>> src/rpa_back.sv
module rpa_back #(
  parameter int NUM_PAGES  = rpa_pkg::NUM_PAGES_DEF,
  parameter int PAGE_SHIFT = rpa_pkg::PAGE_SHIFT_DEF,
  parameter int COUNT_BITS = rpa_pkg::COUNT_BITS_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          mid_empty,
  output logic                                          mid_pop,
  input  logic                                          mid_mode,
  input  logic                                          mid_bad,
  input  logic [rpa_pkg::ADDR_W-PAGE_SHIFT-1:0]         mid_pnum,
  input  logic [$clog2(NUM_PAGES)-1:0]                  mid_slot,
  input  logic                                          res_full,
  output logic                                          res_push,
  output rpa_pkg::out_t                                 res_data,
  output logic                                          clr_busy
);

  localparam int PN_W   = rpa_pkg::ADDR_W - PAGE_SHIFT;
  localparam int SLOT_W = $clog2(NUM_PAGES);
  localparam int DEP_W  = $clog2(NUM_PAGES + 1);
  localparam int STK_W  = PN_W + SLOT_W;
  localparam int EXT_CW = (COUNT_BITS > rpa_pkg::REF_W) ? COUNT_BITS : rpa_pkg::REF_W;

  localparam logic [COUNT_BITS-1:0] CNT_MIN = {1'b1, {(COUNT_BITS - 1){1'b0}}};
  localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

  localparam logic [1:0] S_CLR  = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  // Count table and free stack
  logic [COUNT_BITS-1:0] cnt_mem [NUM_PAGES];
  logic [STK_W-1:0]      stk_mem [NUM_PAGES];

  logic [1:0]              state_r, state_nxt;
  logic [SLOT_W-1:0]       clr_idx_r, clr_idx_nxt;
  logic [DEP_W-1:0]        depth_r, depth_nxt;
  logic                    cur_mode_r, cur_bad_r;
  logic [PN_W-1:0]         cur_pnum_r;
  logic [SLOT_W-1:0]       cur_slot_r;
  logic signed [COUNT_BITS-1:0] cnt_rd_r;
  logic [STK_W-1:0]        stk_rd_r;

  logic                    issue;
  logic [DEP_W-1:0]        depth_m1;
  logic [SLOT_W-1:0]       stk_raddr;
  logic signed [COUNT_BITS-1:0] c_dec;
  logic signed [EXT_CW-1:0]     c_ext;
  logic                    c_pos;
  logic [PN_W-1:0]         stk_pnum;
  logic [SLOT_W-1:0]       stk_slot;
  logic                    cnt_we;
  logic [SLOT_W-1:0]       cnt_waddr;
  logic [COUNT_BITS-1:0]   cnt_wdata;
  logic                    stk_we;

  assign clr_busy  = (state_r == S_CLR);
  assign issue     = (state_r == S_IDLE) && !mid_empty && !res_full;
  assign mid_pop   = issue;
  assign depth_m1  = depth_r - DEP_W'(1);
  assign stk_raddr = depth_m1[SLOT_W-1:0];

  // Saturating decrement of the stored count
  assign c_dec    = (cnt_rd_r == CNT_MIN) ? cnt_rd_r : cnt_rd_r - CNT_ONE;
  assign c_ext    = EXT_CW'(c_dec);
  assign c_pos    = !c_dec[COUNT_BITS-1] && (c_dec != '0);
  assign stk_pnum = stk_rd_r[STK_W-1:SLOT_W];
  assign stk_slot = stk_rd_r[SLOT_W-1:0];

  // Sequence: clear sweep, then issue reads, then write back and report
  always_comb begin
    state_nxt   = state_r;
    clr_idx_nxt = clr_idx_r;
    depth_nxt   = depth_r;
    cnt_we      = 1'b0;
    cnt_waddr   = clr_idx_r;
    cnt_wdata   = '0;
    stk_we      = 1'b0;
    res_push    = 1'b0;
    res_data    = '0;
    case (state_r)
      S_CLR: begin
        cnt_we      = 1'b1;
        clr_idx_nxt = clr_idx_r + SLOT_W'(1);
        if (clr_idx_r == SLOT_W'(NUM_PAGES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (issue) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        res_push  = 1'b1;
        if (cur_bad_r) begin
          res_data.status = rpa_pkg::ST_BADADDR;
        end else if (!cur_mode_r) begin
          if (depth_r == '0) begin
            res_data.status = rpa_pkg::ST_NOFREE;
          end else begin
            cnt_we                = 1'b1;
            cnt_waddr             = stk_slot;
            cnt_wdata             = CNT_ONE;
            depth_nxt             = depth_m1;
            res_data.status       = rpa_pkg::ST_OK;
            res_data.result_addr  = {stk_pnum, {PAGE_SHIFT{1'b0}}};
            res_data.ref_count    = rpa_pkg::REF_W'(1);
          end
        end else begin
          cnt_we             = 1'b1;
          cnt_waddr          = cur_slot_r;
          cnt_wdata          = c_dec;
          res_data.ref_count = c_ext[rpa_pkg::REF_W-1:0];
          if (c_pos) begin
            res_data.status = rpa_pkg::ST_STILLREF;
          end else begin
            res_data.status = rpa_pkg::ST_OK;
            if (depth_r != DEP_W'(NUM_PAGES)) begin
              stk_we    = 1'b1;
              depth_nxt = depth_r + DEP_W'(1);
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      clr_idx_r <= '0;
      depth_r   <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_idx_r <= clr_idx_nxt;
      depth_r   <= depth_nxt;
    end
  end

  // Latch the request taken from the queue
  always_ff @(posedge clk) begin
    if (issue) begin
      cur_mode_r <= mid_mode;
      cur_bad_r  <= mid_bad;
      cur_pnum_r <= mid_pnum;
      cur_slot_r <= mid_slot;
    end
  end

  // Memory ports: one write and one registered read each
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_rd_r <= cnt_mem[mid_slot];
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[depth_r[SLOT_W-1:0]] <= {cur_pnum_r, cur_slot_r};
    end
    stk_rd_r <= stk_mem[stk_raddr];
  end

endmodule

>>> src/refcounted_page_allocator_top.sv
// Page-frame allocator with a LIFO free stack and a per-page reference count
// table. Push a request (allocate, or free of page_addr) on the input queue
// and pop one result per request in order. After reset a clearing sweep
// zeroes every entry of the count table while in_full stays high;
// configuration writes are taken throughout. A request then takes two
// steps in the back end (count and stack read, then write back), and
// the back end takes no new request until the write back is done. When
// NUM_PAGES is not a power of two, a free with a good address spends two
// extra steps in the front classifier reducing its page number to a table
// slot; the classifier takes no new request meanwhile. Fill memory at
// start-up by issuing one free per page.
module refcounted_page_allocator_top #(
  parameter int NUM_PAGES  = rpa_pkg::NUM_PAGES_DEF,
  parameter int PAGE_SHIFT = rpa_pkg::PAGE_SHIFT_DEF,
  parameter int COUNT_BITS = rpa_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  input  rpa_pkg::in_t                      in_data,
  output logic                              in_full,
  output logic                              out_empty,
  input  logic                              out_pop,
  output rpa_pkg::out_t                     out_data,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [rpa_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [rpa_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [rpa_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                              cfg_pready
);

  localparam int PN_W   = rpa_pkg::ADDR_W - PAGE_SHIFT;
  localparam int SLOT_W = $clog2(NUM_PAGES);
  localparam int MID_W  = 2 + PN_W + SLOT_W;
  localparam int OUT_W  = $bits(rpa_pkg::out_t);

  logic [rpa_pkg::ADDR_W-1:0] mem_floor, mem_top;
  logic                       clr_busy;

  logic              f_push, f_mode, f_bad;
  logic [PN_W-1:0]   f_pnum;
  logic [SLOT_W-1:0] f_slot;
  logic              mid_full, mid_empty, mid_pop;
  logic [MID_W-1:0]  mid_rdata;
  logic              b_mode, b_bad;
  logic [PN_W-1:0]   b_pnum;
  logic [SLOT_W-1:0] b_slot;

  logic              res_push, res_full;
  rpa_pkg::out_t     res_data;
  logic [OUT_W-1:0]  out_rdata;

  rpa_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .mem_floor   (mem_floor),
    .mem_top     (mem_top)
  );

  rpa_front #(
    .NUM_PAGES  (NUM_PAGES),
    .PAGE_SHIFT (PAGE_SHIFT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .mem_floor (mem_floor),
    .mem_top   (mem_top),
    .clr_busy  (clr_busy),
    .mid_full  (mid_full),
    .mid_push  (f_push),
    .mid_mode  (f_mode),
    .mid_bad   (f_bad),
    .mid_pnum  (f_pnum),
    .mid_slot  (f_slot)
  );

  // Queue of classified requests
  rpa_fifo #(
    .WIDTH (MID_W),
    .DEPTH (rpa_pkg::MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .wdata ({f_mode, f_bad, f_pnum, f_slot}),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .empty (mid_empty)
  );

  assign {b_mode, b_bad, b_pnum, b_slot} = mid_rdata;

  rpa_back #(
    .NUM_PAGES  (NUM_PAGES),
    .PAGE_SHIFT (PAGE_SHIFT),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mid_empty (mid_empty),
    .mid_pop   (mid_pop),
    .mid_mode  (b_mode),
    .mid_bad   (b_bad),
    .mid_pnum  (b_pnum),
    .mid_slot  (b_slot),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_data  (res_data),
    .clr_busy  (clr_busy)
  );

  // Result queue
  rpa_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (rpa_pkg::OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_data),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (out_rdata),
    .empty (out_empty)
  );

  assign out_data = out_rdata;

endmodule

>>> src/rpa_chk.sv
module rpa_chk (
  input logic          clk,
  input logic          rst_n,
  input logic          in_full,
  input logic          out_empty,
  input logic          out_pop,
  input rpa_pkg::out_t out_data
);

  // Reset empties the result queue and holds off requests for the clear sweep
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> out_empty && in_full)
    else $error("result pending or input open right after reset");

  // Only a successful allocate carries an address
  a_addr_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && (out_data.status != rpa_pkg::ST_OK) |-> out_data.result_addr == '0)
    else $error("address reported on a failed or free beat");

  // Empty stack and bad address report a zero count
  a_fail_zero_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && ((out_data.status == rpa_pkg::ST_NOFREE) ||
                   (out_data.status == rpa_pkg::ST_BADADDR))
    |-> out_data.ref_count == '0)
    else $error("nonzero count on a failed beat");

  // Still referenced means the page count is positive
  a_stillref_pos: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && (out_data.status == rpa_pkg::ST_STILLREF) |-> out_data.ref_count > 0)
    else $error("still-referenced beat with nonpositive count");

  // Hold a result that is not taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_data))
    else $error("waiting result dropped or changed");

endmodule

bind refcounted_page_allocator_top rpa_chk u_rpa_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_full   (in_full),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_data  (out_data)
);
